// File: rtl/core/chacha20_block_keystream_defines.svh
// ----------------------------------------------------------------------------
// chacha20_block_keystream_defines.svh
// Assertion macros shared by the keystream core files
// ----------------------------------------------------------------------------
`ifndef CHACHA20_BLOCK_KEYSTREAM_DEFINES_SVH
`define CHACHA20_BLOCK_KEYSTREAM_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define CC20KS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define CC20KS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cc20ks_pkg.sv
// ----------------------------------------------------------------------------
// cc20ks_pkg
// Types, constants and quarter-round helpers for the ChaCha20 keystream core
// ----------------------------------------------------------------------------
package cc20ks_pkg;

    typedef logic [15:0][31:0] state_t;
    typedef logic [7:0][31:0]  key_t;
    typedef logic [2:0][31:0]  nonce_t;
    typedef logic [2:0]        cfg_idx_t;

    // one pipeline beat: valid, counter word and working state
    typedef struct packed {
        logic        valid;
        logic [31:0] ctr;
        state_t      st;
    } beat_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_words_t;

    // "expand 32-byte k" as little-endian words, word 0 lowest
    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    localparam cfg_idx_t CFG_KEY_01   = 3'd0;
    localparam cfg_idx_t CFG_KEY_23   = 3'd1;
    localparam cfg_idx_t CFG_KEY_45   = 3'd2;
    localparam cfg_idx_t CFG_KEY_67   = 3'd3;
    localparam cfg_idx_t CFG_NONCE_01 = 3'd4;
    localparam cfg_idx_t CFG_NONCE_2  = 3'd5;

    function automatic state_t build_init(input key_t key, input nonce_t nonce,
                                          input logic [31:0] ctr);
        state_t st;
        st[3:0]   = SIGMA;
        st[11:4]  = key;
        st[12]    = ctr;
        st[15:13] = nonce;
        return st;
    endfunction

    // half a quarter round: first half rotates 16/12, second half 8/7
    function automatic qr_words_t qr_half(input qr_words_t w, input logic second);
        qr_words_t   r;
        logic [31:0] x;
        r.a = w.a + w.b;
        x   = w.d ^ r.a;
        r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        r.c = w.c + r.d;
        x   = w.b ^ r.c;
        r.b = second ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
        return r;
    endfunction

endpackage

// File: rtl/core/chacha20_block_keystream.sv
// ----------------------------------------------------------------------------
// chacha20_block_keystream
// ChaCha20 block function, one 512-bit keystream block per block counter
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[31:0]   block counter
//   m_       out  m_tvalid/m_tready  m_tdata[511:0]  keystream words 0..15
//   cfg_     in   cfg_valid/ready    cfg_index[2:0], cfg_data[63:0]
//
// one block per cycle while the skid stage is empty, with
//   one register stage per half quarter round plus the final add/output stage
// cfg_ready is always high; key and nonce feed the first and last stage
// aresetn clears the valid bits, the skid's included, and the key/nonce registers to zero
// a held output beat parks the next one in a skid stage; s_tready drops
//   only while that skid is full, and the whole pipe then holds in place
// ----------------------------------------------------------------------------
`include "chacha20_block_keystream_defines.svh"

module chacha20_block_keystream #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // block_counter
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [511:0]         m_tdata,    // stream_words_0_1 .. stream_words_14_15
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cc20ks_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]          cfg_data
);
    import cc20ks_pkg::*;

    localparam int NSTAGE = 4 * DOUBLE_ROUNDS;

    key_t   key_reg;
    nonce_t nonce_reg;
    logic   pipe_en;
    beat_t  pipe [NSTAGE + 1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY_01:   key_reg[1:0]   <= cfg_data;
                CFG_KEY_23:   key_reg[3:2]   <= cfg_data;
                CFG_KEY_45:   key_reg[5:4]   <= cfg_data;
                CFG_KEY_67:   key_reg[7:6]   <= cfg_data;
                CFG_NONCE_01: nonce_reg[1:0] <= cfg_data;
                CFG_NONCE_2:  nonce_reg[2]   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign s_tready = pipe_en;
    assign pipe[0]  = '{valid: s_tvalid, ctr: s_tdata,
                        st: build_init(key_reg, nonce_reg, s_tdata)};

    // stage order per double round: column 16/12, column 8/7, diagonal 16/12, diagonal 8/7
    for (genvar g = 0; g < NSTAGE; g++) begin : g_round
        cc20ks_round_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .diag     (((g / 2) % 2) == 1),
            .second   ((g % 2) == 1),
            .in_beat  (pipe[g]),
            .out_beat (pipe[g + 1])
        );
    end

    cc20ks_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (pipe[NSTAGE]),
        .key      (key_reg),
        .nonce    (nonce_reg),
        .pipe_en  (pipe_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `CC20KS_ASSERT_NOW(a_backpressure_source, !s_tready, m_tvalid, "input blocked with no output beat held")
    `CC20KS_ASSERT_NEXT(a_stall_releases, !s_tready && m_tready, s_tready, "input stays blocked after output drained")

endmodule

// File: rtl/core/cc20ks_round_stage.sv
// ----------------------------------------------------------------------------
// cc20ks_round_stage
// One pipeline stage: half of a column or diagonal round on all four quarters
// ----------------------------------------------------------------------------
module cc20ks_round_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              diag,
    input  logic              second,
    input  cc20ks_pkg::beat_t in_beat,
    output cc20ks_pkg::beat_t out_beat
);
    import cc20ks_pkg::*;

    logic        valid_reg;
    logic [31:0] ctr_reg;
    state_t      st_reg;
    state_t      st_next;

    always_comb begin
        logic [1:0] qi;
        logic [1:0] qb;
        logic [1:0] qc;
        logic [1:0] qd;
        qr_words_t  w;
        qr_words_t  r;
        st_next = in_beat.st;
        for (int q = 0; q < 4; q++) begin
            qi = 2'(q);
            qb = diag ? qi + 2'd1 : qi;
            qc = diag ? qi + 2'd2 : qi;
            qd = diag ? qi + 2'd3 : qi;
            w.a = in_beat.st[{2'b00, qi}];
            w.b = in_beat.st[{2'b01, qb}];
            w.c = in_beat.st[{2'b10, qc}];
            w.d = in_beat.st[{2'b11, qd}];
            r = qr_half(w, second);
            st_next[{2'b00, qi}] = r.a;
            st_next[{2'b01, qb}] = r.b;
            st_next[{2'b10, qc}] = r.c;
            st_next[{2'b11, qd}] = r.d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_beat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctr_reg <= in_beat.ctr;
            st_reg  <= st_next;
        end
    end

    assign out_beat = '{valid: valid_reg, ctr: ctr_reg, st: st_reg};

endmodule

// File: rtl/core/cc20ks_out_stage.sv
// ----------------------------------------------------------------------------
// cc20ks_out_stage
// Feed-forward add of the initial state, output register and skid buffer
// ----------------------------------------------------------------------------
`include "chacha20_block_keystream_defines.svh"

module cc20ks_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  cc20ks_pkg::beat_t in_beat,
    input  cc20ks_pkg::key_t   key,
    input  cc20ks_pkg::nonce_t nonce,
    output logic              pipe_en,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [511:0]      m_tdata   // stream words 0..15, word 0 lowest
);
    import cc20ks_pkg::*;

    logic   m_tvalid_reg;
    state_t m_data_reg;
    logic   skid_valid_reg;
    state_t skid_data_reg;
    state_t init_st;
    state_t sum_next;
    logic   out_take;
    logic   in_fire;

    // ctr in pipe; user holds key, nonce while items in flight; unenforced
    assign init_st = build_init(key, nonce, in_beat.ctr);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sum_next[i] = in_beat.st[i] + init_st[i];
        end
    end

    assign pipe_en  = !skid_valid_reg;
    assign in_fire  = pipe_en && in_beat.valid;
    assign out_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_tvalid_reg   <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : sum_next;
        end else if (in_fire) begin
            skid_data_reg <= sum_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `CC20KS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_tvalid_reg, "skid full with empty output")
    `CC20KS_ASSERT_NEXT(a_stall_to_skid, in_fire && m_tvalid_reg && !m_tready, skid_valid_reg, "beat on stalled output missed the skid")
    `CC20KS_ASSERT_NEXT(a_skid_drain, skid_valid_reg && m_tready, !skid_valid_reg && m_tvalid_reg, "skid beat not moved to output")

endmodule

// File: verif/chacha20_block_keystream_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chacha20_block_keystream_tb
// Self-checking bench for the ChaCha20 keystream core. Block counters go in
// on the s_ stream and every 512-bit keystream beat on the m_ stream is
// compared word pair by word pair against a behavioral ChaCha20 block
// function. Key and nonce are reprogrammed between drained phases. Both
// stream sides insert random idle gaps.
// ----------------------------------------------------------------------------
module chacha20_block_keystream_tb;
    import cc20ks_pkg::*;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int FIELDS        = 8;
    localparam int MAX_IDLE      = 15;
    localparam int TAIL_CYCLES   = 4 * DOUBLE_ROUNDS + 20;

    // indexes past the last register; writes to them must be dropped
    localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
    localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } lane_quad_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [31:0]    s_tdata;    // block_counter
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [511:0]   m_tdata;    // stream_words_0_1 .. stream_words_14_15
    logic           cfg_valid;
    logic           cfg_ready;
    cfg_idx_t       cfg_index;
    logic [63:0]    cfg_data;

    // shadow copy of the key and nonce registers
    logic [63:0]    key_pair [4];
    logic [63:0]    nonce_pair;
    logic [31:0]    nonce_tail;

    logic [511:0]   keystream_q [$];
    logic [511:0]   expected_block;
    int unsigned    errors = 0;
    bit             tx_idle_en = 1'b1;
    bit             rx_idle_en = 1'b1;
    bit             beat_taken = 1'b0;
    int             stall_left = 0;

    chacha20_block_keystream #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic lane_quad_t quarter_round(input lane_quad_t q);
        lane_quad_t r;
        r = q;
        r.a = r.a + r.b;  r.d = rotl32(r.d ^ r.a, 16);
        r.c = r.c + r.d;  r.b = rotl32(r.b ^ r.c, 12);
        r.a = r.a + r.b;  r.d = rotl32(r.d ^ r.a, 8);
        r.c = r.c + r.d;  r.b = rotl32(r.b ^ r.c, 7);
        return r;
    endfunction

    // full block function on the shadow key/nonce for one counter value
    function automatic logic [511:0] chacha_keystream(input logic [31:0] ctr);
        logic [31:0]  init_w [16];
        logic [31:0]  work_w [16];
        logic [511:0] blk;
        lane_quad_t   q;
        int           ia, ib, ic, id, s;
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = SIGMA[i];
            init_w[4 + 2 * i] = key_pair[i][31:0];
            init_w[5 + 2 * i] = key_pair[i][63:32];
        end
        init_w[12] = ctr;
        init_w[13] = nonce_pair[31:0];
        init_w[14] = nonce_pair[63:32];
        init_w[15] = nonce_tail;
        work_w = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // s = 0: column round, s = 1: diagonal round
            for (int h = 0; h < 8; h++) begin
                s  = h / 4;
                ia = h % 4;
                ib = 4 + (ia + s) % 4;
                ic = 8 + (ia + 2 * s) % 4;
                id = 12 + (ia + 3 * s) % 4;
                q = quarter_round({work_w[ia], work_w[ib], work_w[ic], work_w[id]});
                work_w[ia] = q.a;
                work_w[ib] = q.b;
                work_w[ic] = q.c;
                work_w[id] = q.d;
            end
        end
        for (int i = 0; i < 16; i++)
            blk[32 * i +: 32] = work_w[i] + init_w[i];
        return blk;
    endfunction

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // all stimulus tasks start and return on a falling edge
    task automatic send_counter(input logic [31:0] ctr);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ctr;
        do @(posedge aclk); while (!s_tready);
        keystream_q.push_back(chacha_keystream(ctr));
        @(negedge aclk);
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_register(input cfg_idx_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_KEY_01:   key_pair[0] = value;
            CFG_KEY_23:   key_pair[1] = value;
            CFG_KEY_45:   key_pair[2] = value;
            CFG_KEY_67:   key_pair[3] = value;
            CFG_NONCE_01: nonce_pair  = value;
            CFG_NONCE_2:  nonce_tail  = value[31:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_registers(input logic [63:0] k01, input logic [63:0] k23,
                                     input logic [63:0] k45, input logic [63:0] k67,
                                     input logic [63:0] n01, input logic [63:0] n2);
        write_register(CFG_KEY_01, k01);
        write_register(CFG_KEY_23, k23);
        write_register(CFG_KEY_45, k45);
        write_register(CFG_KEY_67, k67);
        write_register(CFG_NONCE_01, n01);
        write_register(CFG_NONCE_2, n2);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (keystream_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // key and nonce still at their reset value of zero
    task automatic test_zero_key();
        send_counter(32'h0000_0000);
        send_counter(32'h0000_0001);
        send_counter(32'hFFFF_FFFF);
        send_counter(32'h8000_0000);
        drain_pipeline();
    endtask

    // RFC 7539 block function example: key 00..1f, counter 1
    task automatic test_rfc_vector();
        logic [511:0] ks;
        program_registers(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                          64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                          64'h4a00_0000_0900_0000, 64'h0);
        cfg_valid <= 1'b0;
        ks = chacha_keystream(32'd1);
        if (ks[31:0] !== 32'he4e7_f110) begin
            $error("stream_words_0_1 expected %h actual %h (rfc vector)",
                   32'he4e7_f110, ks[31:0]);
            errors++;
        end
        send_counter(32'h0000_0001);
        send_counter(32'h0000_0000);
        send_counter(32'hFFFF_FFFF);
        drain_pipeline();
    endtask

    // every register bit set; nonce word 2 write also carries bits above 32
    task automatic test_saturated_registers();
        program_registers('1, '1, '1, '1, '1, '1);
        cfg_valid <= 1'b0;
        send_counter(32'h0000_0000);
        send_counter(32'hFFFF_FFFF);
        send_counter(32'h5555_5555);
        send_counter(32'hAAAA_AAAA);
        drain_pipeline();
    endtask

    // unused indexes are dropped, upper half of nonce word 2 is masked
    task automatic test_register_index();
        program_registers(64'h0123_4567_89ab_cdef, 64'h0, 64'hFFFF_FFFF_0000_0000,
                          64'h0000_0000_FFFF_FFFF, 64'h8000_0000_0000_0001,
                          64'h0);
        write_register(CFG_SPARE_6, '1);
        write_register(CFG_SPARE_7, 64'hdead_beef_cafe_f00d);
        write_register(CFG_NONCE_2, 64'hdead_beef_0000_0001);
        cfg_valid <= 1'b0;
        send_counter(32'h0000_0002);
        send_counter(32'h7FFF_FFFF);
        send_counter(32'hFFFF_FFFE);
        drain_pipeline();
    endtask

    // phases of mostly sequential counters under fresh keys, idling varied per phase
    task automatic test_random_keystream();
        logic [31:0] base;
        for (int ph = 0; ph < 10; ph++) begin
            tx_idle_en = ph[0];
            rx_idle_en = ph[1];
            program_registers(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                              pick_reg_value(), pick_reg_value(), {$urandom, $urandom});
            write_register($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                           {$urandom, $urandom});
            cfg_valid <= 1'b0;
            // last phase walks the counter across its wrap
            base = (ph == 9) ? 32'hFFFF_FFC0 : $urandom;
            for (int n = 0; n < 85; n++)
                send_counter(($urandom_range(0, 3) == 0) ? $urandom : base + n);
            drain_pipeline();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver: random stall after each accepted beat
    always @(negedge aclk) begin
        if (beat_taken) begin
            beat_taken = 1'b0;
            stall_left = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beat_taken = 1'b1;
            if (keystream_q.size() == 0) begin
                $error("keystream beat with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                expected_block = keystream_q.pop_front();
                for (int k = 0; k < FIELDS; k++) begin
                    if (m_tdata[64 * k +: 64] !== expected_block[64 * k +: 64]) begin
                        $error("stream_words_%0d_%0d expected %h actual %h", 2 * k,
                               2 * k + 1, expected_block[64 * k +: 64],
                               m_tdata[64 * k +: 64]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_KEY_01;
        cfg_data   = '0;
        for (int i = 0; i < 4; i++)
            key_pair[i] = '0;
        nonce_pair = '0;
        nonce_tail = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_key();
        test_rfc_vector();
        test_saturated_registers();
        test_register_index();
        test_random_keystream();

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("chacha20_block_keystream_tb OK");
        end else begin
            $display("chacha20_block_keystream_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("chacha20_block_keystream_tb NOT OK");
        $finish;
    end

endmodule
